FILE: design/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the framed packet checker
// Holds the status codes, the result record, the register indexes and the
// byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int HEADER_BYTES_DEF = 12;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [7:0]  START_MARKER_RST = 8'hFF;
	localparam logic [15:0] MAX_LENGTH_RST   = 16'd100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_MARKER = 1'b0,
		CFG_MAX_LENGTH   = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_CRC_OK    = 2'd0,
		ST_CRC_BAD   = 2'd1,
		ST_HDR_ERR   = 2'd2,
		ST_LEN_ERR   = 2'd3
	} status_t;

	typedef struct packed {
		status_t      status;
		logic [15:0]  frame_length;
		logic [31:0]  crc_received;
		logic [31:0]  crc_computed;
	} result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

FILE: design/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_if: stream interfaces of the framed packet checker
// A byte channel toward the checker and a result channel out of it, both
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] frame_length;
	logic [31:0] crc_received;
	logic [31:0] crc_computed;

	modport source (output valid, output status, output frame_length,
		output crc_received, output crc_computed, input ready);
	modport sink   (input valid, input status, input frame_length,
		input crc_received, input crc_computed, output ready);
endinterface

FILE: design/framed_packet_checker_crc32.sv
// ----------------------------------------------------------------------------
// framed_packet_checker_crc32: byte stream deframer with header checksum and CRC-32
// Path: a closing byte is registered first, then its result in the output register.
// Throughput: one byte per cycle; a closing byte waits only while a result is held.
// Reset: hunting for the start marker, marker 0xFF, max length 100, no result.
// ----------------------------------------------------------------------------
module framed_packet_checker_crc32 #(
	parameter int HEADER_BYTES = fpc_pkg::HEADER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fpc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	fpc_byte_if.sink                        rx,
	fpc_result_if.source                    report
);

	logic [7:0]       start_marker_q;
	logic [15:0]      max_length_q;
	logic             v_s1;
	logic [7:0]       b_s1;
	logic             out_v_q;
	fpc_pkg::result_t out_q;
	logic             emit;
	fpc_pkg::result_t res;
	logic             out_free;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= fpc_pkg::START_MARKER_RST;
			max_length_q   <= fpc_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (fpc_pkg::cfg_index_t'(cfg_index))
				fpc_pkg::CFG_START_MARKER: start_marker_q <= cfg_wdata[7:0];
				fpc_pkg::CFG_MAX_LENGTH:   max_length_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_v_q || report.ready;
	// advance a byte unless it closes a frame while the result slot is busy
	assign advance  = v_s1 && (!emit || out_free);
	assign rx.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rx.valid && rx.ready)
			v_s1 <= 1'b1;
		else if (advance)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			b_s1 <= rx.rx_byte;
	end

	fpc_parser #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.b            (b_s1),
		.start_marker (start_marker_q),
		.max_length   (max_length_q),
		.emit         (emit),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (advance && emit)
			out_v_q <= 1'b1;
		else if (report.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			out_q <= res;
	end

	assign report.valid        = out_v_q;
	assign report.status       = out_q.status;
	assign report.frame_length = out_q.frame_length;
	assign report.crc_received = out_q.crc_received;
	assign report.crc_computed = out_q.crc_computed;

`ifndef SYNTH
	a_crc_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status == fpc_pkg::ST_CRC_OK)
		|-> (out_q.crc_received == out_q.crc_computed))
		else $error("crc match reported with differing values");

	a_crc_bad_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status == fpc_pkg::ST_CRC_BAD)
		|-> (out_q.crc_received != out_q.crc_computed))
		else $error("crc mismatch reported with equal values");

	a_hdr_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status == fpc_pkg::ST_HDR_ERR)
		|-> (out_q.frame_length == 16'd0 && out_q.crc_received == 32'd0
			&& out_q.crc_computed == 32'd0))
		else $error("header error result carries nonzero fields");

	a_len_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status == fpc_pkg::ST_LEN_ERR)
		|-> (out_q.frame_length < 16'(HEADER_BYTES + 5)
			|| out_q.frame_length > max_length_q))
		else $error("length error reported for an in-range length");
`endif

endmodule

FILE: design/fpc_parser.sv
// ----------------------------------------------------------------------------
// fpc_parser: frame state tracker
// Holds byte count, length field, header sum, running CRC and captured CRC;
// flags the byte that closes a frame and forms its result.
// ----------------------------------------------------------------------------
module fpc_parser #(
	parameter int HEADER_BYTES = fpc_pkg::HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        b,
	input  logic [7:0]        start_marker,
	input  logic [15:0]       max_length,
	output logic              emit,
	output fpc_pkg::result_t  res
);

	localparam logic [15:0] CHK_IDX   = 16'(HEADER_BYTES - 1);
	localparam logic [15:0] MIN_FRAME = 16'(HEADER_BYTES + 5);

	logic [15:0] count_q, count_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] cap_q, cap_d;
	logic [31:0] crc_next;
	logic [15:0] count_inc;
	logic [7:0]  sum_neg;

	assign crc_next  = fpc_pkg::crc32_byte(crc_q, b);
	assign count_inc = count_q + 16'd1;
	assign sum_neg   = 8'd0 - sum_q;

	always_comb begin
		count_d = count_q;
		len_d   = len_q;
		sum_d   = sum_q;
		crc_d   = crc_q;
		cap_d   = cap_q;
		emit    = 1'b0;
		res     = '{status: fpc_pkg::ST_CRC_OK, frame_length: 16'd0,
			crc_received: 32'd0, crc_computed: 32'd0};

		if (count_q == 16'd0) begin
			// hunt for the start marker
			if (b == start_marker) begin
				len_d   = 16'd0;
				sum_d   = b;
				crc_d   = fpc_pkg::crc32_byte(fpc_pkg::CRC_INIT, b);
				cap_d   = 32'd0;
				count_d = 16'd1;
			end
		end else if (count_q < CHK_IDX) begin
			sum_d = sum_q + b;
			if (count_q == 16'd1)
				len_d = {b, len_q[7:0]};
			else if (count_q == 16'd2)
				len_d = {len_q[15:8], b};
			crc_d   = crc_next;
			count_d = count_inc;
		end else if (count_q == CHK_IDX) begin
			crc_d = crc_next;
			if (b != sum_neg) begin
				emit       = 1'b1;
				res.status = fpc_pkg::ST_HDR_ERR;
			end else if (len_q < MIN_FRAME || len_q > max_length) begin
				emit             = 1'b1;
				res.status       = fpc_pkg::ST_LEN_ERR;
				res.frame_length = len_q;
			end else begin
				count_d = count_inc;
			end
		end else begin
			// body: CRC over data, then four CRC bytes, then the stop byte
			if (count_q < len_q - 16'd5)
				crc_d = crc_next;
			else if (count_q < len_q - 16'd1)
				cap_d = {cap_q[23:0], b};
			count_d = count_inc;
			if (count_inc == len_q) begin
				emit             = 1'b1;
				res.status       = (cap_q == ~crc_q) ? fpc_pkg::ST_CRC_OK
				                                     : fpc_pkg::ST_CRC_BAD;
				res.frame_length = len_q;
				res.crc_received = cap_q;
				res.crc_computed = ~crc_q;
			end
		end

		if (emit) begin
			count_d = 16'd0;
			len_d   = 16'd0;
			sum_d   = 8'd0;
			crc_d   = fpc_pkg::CRC_INIT;
			cap_d   = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
			len_q   <= 16'd0;
			sum_q   <= 8'd0;
			crc_q   <= fpc_pkg::CRC_INIT;
			cap_q   <= 32'd0;
		end else if (step) begin
			count_q <= count_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			crc_q   <= crc_d;
			cap_q   <= cap_d;
		end
	end

endmodule
